/* sv/lfps_pkg.sv */
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types and constants for the two-sensor line follower with PD steering.
// ----------------------------------------------------------------------------
package lfps_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int PWM_TOP     = 1024;

  localparam int ALIGN_W = 11;
  localparam int PGAIN_W = 12;
  localparam int DGAIN_W = 7;
  localparam int CFG_W   = 12;
  localparam int SPEED_W = 11;

  localparam int DIFF_W  = SAMPLE_BITS + 1;
  localparam int DDIFF_W = DIFF_W + 1;
  localparam int PPROD_W = PGAIN_W + 1 + DIFF_W;
  localparam int DPROD_W = DGAIN_W + 1 + DDIFF_W;
  localparam int NUM_W   = PPROD_W;
  localparam int MAG_W   = NUM_W - 1;

  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W     = 26;
  localparam int QPROD_W     = MAG_W + RECIP_W;
  localparam int QUO_W       = QPROD_W - RECIP_SHIFT;
  localparam int TURN_W      = QUO_W + 1;
  localparam int WHEEL_W     = 18;

  localparam logic [SAMPLE_BITS-1:0] BLACK_LEVEL = SAMPLE_BITS'(12'hA00);
  localparam logic [RECIP_W-1:0]     DIV_RECIP   = RECIP_W'(34359739);
  localparam int BASE_SPEED  = 230;
  localparam int SIDE_OFFSET = 60;

  localparam logic [1:0] CFG_ALIGN = 2'd0;
  localparam logic [1:0] CFG_PGAIN = 2'd1;
  localparam logic [1:0] CFG_DGAIN = 2'd2;

  typedef enum logic [1:0] {
    MODE_WHITE = 2'd0,
    MODE_PD    = 2'd1,
    MODE_LEFT  = 2'd2,
    MODE_RIGHT = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [NUM_W-1:0]   num;
  } num_beat_t;

  typedef struct packed {
    mode_t              mode;
    logic               neg;
    logic [QUO_W-1:0]   quo;
  } quo_beat_t;

endpackage

/* sv/lfps_front.sv */
// ----------------------------------------------------------------------------
// lfps_front
// Sample register, classification, side memory and PD numerator products.
// ----------------------------------------------------------------------------
module lfps_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lfps_pkg::SAMPLE_BITS-1:0] in_left_sample,
  input  logic [lfps_pkg::SAMPLE_BITS-1:0] in_right_sample,
  input  logic [lfps_pkg::PGAIN_W-1:0]   prop_gain,
  input  logic [lfps_pkg::DGAIN_W-1:0]   deriv_gain,
  input  logic                           dn_ready,
  output logic                           num_valid,
  output lfps_pkg::num_beat_t            num_beat
);
  import lfps_pkg::*;

  logic                    s0_valid_r;
  logic [SAMPLE_BITS-1:0]  left_r;
  logic [SAMPLE_BITS-1:0]  right_r;
  logic                    s1_valid_r;
  num_beat_t               beat_r;
  num_beat_t               beat_nxt;
  mode_t                   side_r;
  mode_t                   side_nxt;
  logic signed [DIFF_W-1:0] last_diff_r;
  logic signed [DIFF_W-1:0] last_diff_nxt;

  logic                     s0_ready;
  logic                     s1_ready;
  logic                     s0_fire;
  mode_t                    cls;
  mode_t                    mode;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DDIFF_W-1:0] ddiff;
  logic signed [PPROD_W-1:0] prod_p;
  logic signed [DPROD_W-1:0] prod_d;
  logic signed [NUM_W-1:0]   num;

  assign s1_ready  = !s1_valid_r || dn_ready;
  assign s0_ready  = !s0_valid_r || s1_ready;
  assign s0_fire   = s0_valid_r && s1_ready;
  assign in_stall  = !s0_ready;
  assign num_valid = s1_valid_r;
  assign num_beat  = beat_r;

  always_comb begin
    if (left_r < BLACK_LEVEL && right_r < BLACK_LEVEL) begin
      cls = MODE_WHITE;
    end else if (left_r > BLACK_LEVEL && right_r > BLACK_LEVEL) begin
      cls = MODE_PD;
    end else if (right_r > BLACK_LEVEL && left_r < BLACK_LEVEL) begin
      cls = MODE_RIGHT;
    end else begin
      cls = MODE_LEFT;
    end
  end

  always_comb begin
    side_nxt = side_r;
    case (cls) inside
      MODE_LEFT, MODE_RIGHT: begin
        side_nxt = cls;
        mode     = MODE_PD;
      end
      MODE_PD: mode = MODE_PD;
      default: mode = side_r;
    endcase
  end

  assign diff   = $signed({1'b0, left_r}) - $signed({1'b0, right_r});
  assign ddiff  = $signed({diff[DIFF_W-1], diff}) -
                  $signed({last_diff_r[DIFF_W-1], last_diff_r});
  assign prod_p = $signed({1'b0, prop_gain}) * diff;
  assign prod_d = $signed({1'b0, deriv_gain}) * ddiff;
  assign num    = prod_p + NUM_W'(prod_d);

  always_comb begin
    last_diff_nxt = (mode == MODE_PD) ? diff : last_diff_r;
    beat_nxt.mode = mode;
    beat_nxt.num  = (mode == MODE_PD) ? num : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && in_valid) begin
      left_r  <= in_left_sample;
      right_r <= in_right_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= MODE_WHITE;
      last_diff_r <= '0;
    end else if (s0_fire) begin
      side_r      <= side_nxt;
      last_diff_r <= last_diff_nxt;
    end
  end

endmodule

/* sv/lfps_div.sv */
// ----------------------------------------------------------------------------
// lfps_div
// Divides the PD numerator by 2000 through an exact reciprocal multiply.
// ----------------------------------------------------------------------------
module lfps_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                num_valid,
  output logic                num_ready,
  input  lfps_pkg::num_beat_t num_beat,
  input  logic                dn_ready,
  output logic                quo_valid,
  output lfps_pkg::quo_beat_t quo_beat
);
  import lfps_pkg::*;

  logic              valid_r;
  quo_beat_t         beat_r;
  quo_beat_t         beat_nxt;
  logic              neg;
  logic [NUM_W-1:0]  mag_full;
  logic [QPROD_W-1:0] qprod;

  assign num_ready = !valid_r || dn_ready;
  assign quo_valid = valid_r;
  assign quo_beat  = beat_r;

  assign neg      = num_beat.num[NUM_W-1];
  assign mag_full = neg ? (~num_beat.num + NUM_W'(1)) : num_beat.num;
  assign qprod    = QPROD_W'(mag_full[MAG_W-1:0]) * QPROD_W'(DIV_RECIP);

  always_comb begin
    beat_nxt.mode = num_beat.mode;
    beat_nxt.neg  = neg;
    beat_nxt.quo  = qprod[QPROD_W-1:RECIP_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (num_ready) begin
      valid_r <= num_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (num_ready && num_valid) begin
      beat_r <= beat_nxt;
    end
  end

endmodule

/* sv/lfps_out.sv */
// ----------------------------------------------------------------------------
// lfps_out
// Turn selection, wheel sums with alignment trim, clamp and result register.
// ----------------------------------------------------------------------------
module lfps_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         quo_valid,
  output logic                         quo_ready,
  input  lfps_pkg::quo_beat_t          quo_beat,
  input  logic [lfps_pkg::ALIGN_W-1:0] wheel_alignment,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lfps_pkg::SPEED_W-1:0] out_left_speed,
  output logic [lfps_pkg::SPEED_W-1:0] out_right_speed,
  output logic [1:0]                   out_drive_mode
);
  import lfps_pkg::*;

  localparam logic signed [WHEEL_W-1:0] WheelLim = WHEEL_W'(PWM_TOP);
  localparam logic signed [WHEEL_W-1:0] BaseW    = WHEEL_W'(BASE_SPEED);
  localparam logic signed [TURN_W-1:0]  SideW    = TURN_W'(SIDE_OFFSET);

  logic                  valid_r;
  logic [SPEED_W-1:0]    left_r;
  logic [SPEED_W-1:0]    right_r;
  logic [1:0]            mode_r;
  logic [SPEED_W-1:0]    left_nxt;
  logic [SPEED_W-1:0]    right_nxt;

  logic signed [TURN_W-1:0]  quo_s;
  logic signed [TURN_W-1:0]  turn;
  logic signed [WHEEL_W-1:0] align_w;
  logic signed [WHEEL_W-1:0] turn_w;
  logic signed [WHEEL_W-1:0] left_w;
  logic signed [WHEEL_W-1:0] right_w;

  function automatic logic [SPEED_W-1:0] clamp_wheel(input logic signed [WHEEL_W-1:0] v);
    logic [SPEED_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > WheelLim) begin
      res = WheelLim[SPEED_W-1:0];
    end else begin
      res = v[SPEED_W-1:0];
    end
    return res;
  endfunction

  assign quo_ready       = !valid_r || !out_stall;
  assign out_valid       = valid_r;
  assign out_left_speed  = left_r;
  assign out_right_speed = right_r;
  assign out_drive_mode  = mode_r;

  assign quo_s = $signed({1'b0, quo_beat.quo});

  always_comb begin
    case (quo_beat.mode)
      MODE_PD:    turn = quo_beat.neg ? -quo_s : quo_s;
      MODE_LEFT:  turn = SideW;
      MODE_RIGHT: turn = -SideW;
      default:    turn = '0;
    endcase
  end

  assign align_w   = WHEEL_W'($signed(wheel_alignment));
  assign turn_w    = WHEEL_W'(turn);
  assign left_w    = BaseW + align_w - turn_w;
  assign right_w   = BaseW - align_w + turn_w;
  assign left_nxt  = clamp_wheel(left_w);
  assign right_nxt = clamp_wheel(right_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (quo_ready) begin
      valid_r <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (quo_ready && quo_valid) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      mode_r  <= quo_beat.mode;
    end
  end

endmodule

/* sv/ir_line_follow_pd_steer.sv */
// ----------------------------------------------------------------------------
// ir_line_follow_pd_steer
// Two-sensor infrared line follower producing PD-steered wheel PWM values.
//
//   Channel  Ports                                   Handshake
//   input    in_left_sample, in_right_sample         in_valid / in_stall
//   result   out_left_speed, out_right_speed,        out_valid / out_stall
//            out_drive_mode
//   config   cfg_index, cfg_data                     cfg_wr_en
//
// One beat is accepted per cycle while in_stall is low.
// The path is a sample register, the gain products, the reciprocal divide
// by 2000 and the clamped result register, each stage holding its own beat.
// Reset clears all valid bits, the side memory, the last difference and
// the gains to their defaults. A stalled result holds its stage while
// earlier stages keep filling, so the input stalls only once every stage
// is occupied.
// ----------------------------------------------------------------------------
module ir_line_follow_pd_steer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lfps_pkg::SAMPLE_BITS-1:0] in_left_sample,
  input  logic [lfps_pkg::SAMPLE_BITS-1:0] in_right_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lfps_pkg::SPEED_W-1:0]     out_left_speed,
  output logic [lfps_pkg::SPEED_W-1:0]     out_right_speed,
  output logic [1:0]                       out_drive_mode,
  input  logic                             cfg_wr_en,
  input  logic [1:0]                       cfg_index,
  input  logic [lfps_pkg::CFG_W-1:0]       cfg_data
);
  import lfps_pkg::*;

  logic [ALIGN_W-1:0] align_r;
  logic [PGAIN_W-1:0] pgain_r;
  logic [DGAIN_W-1:0] dgain_r;

  logic      num_valid;
  logic      num_ready;
  num_beat_t num_beat;
  logic      quo_valid;
  logic      quo_ready;
  quo_beat_t quo_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= '0;
      pgain_r <= PGAIN_W'(1600);
      dgain_r <= DGAIN_W'(5);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ALIGN: align_r <= cfg_data[ALIGN_W-1:0];
        CFG_PGAIN: pgain_r <= cfg_data[PGAIN_W-1:0];
        CFG_DGAIN: dgain_r <= cfg_data[DGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  lfps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_left_sample (in_left_sample),
    .in_right_sample(in_right_sample),
    .prop_gain      (pgain_r),
    .deriv_gain     (dgain_r),
    .dn_ready       (num_ready),
    .num_valid      (num_valid),
    .num_beat       (num_beat)
  );

  lfps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .num_valid(num_valid),
    .num_ready(num_ready),
    .num_beat (num_beat),
    .dn_ready (quo_ready),
    .quo_valid(quo_valid),
    .quo_beat (quo_beat)
  );

  lfps_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .quo_valid      (quo_valid),
    .quo_ready      (quo_ready),
    .quo_beat       (quo_beat),
    .wheel_alignment(align_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_speed (out_left_speed),
    .out_right_speed(out_right_speed),
    .out_drive_mode (out_drive_mode)
  );

endmodule

/* test/line_follow_checker.sv */
// ----------------------------------------------------------------------------
// line_follow_checker
// Watches the sample and wheel channels of the line follower. It predicts the
// wheel command for every accepted sample pair from its own copy of the side
// memory, the last difference and the register settings. It then compares
// each accepted result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module line_follow_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [lfps_pkg::SAMPLE_BITS-1:0] in_left_sample,
  input  logic [lfps_pkg::SAMPLE_BITS-1:0] in_right_sample,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [lfps_pkg::SPEED_W-1:0]     out_left_speed,
  input  logic [lfps_pkg::SPEED_W-1:0]     out_right_speed,
  input  logic [1:0]                       out_drive_mode,
  input  logic                             cfg_wr_en,
  input  logic [1:0]                       cfg_index,
  input  logic [lfps_pkg::CFG_W-1:0]       cfg_data,
  output int                               fail_count,
  output int                               wheels_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import lfps_pkg::*;

  localparam int TURN_DIVISOR = 2000;

  typedef struct packed {
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    mode_t              mode;
  } wheel_cmd_t;

  logic signed [ALIGN_W-1:0] trim;
  logic [PGAIN_W-1:0]        p_gain;
  logic [DGAIN_W-1:0]        d_gain;
  mode_t                     side_mem;
  longint                    prev_diff;
  wheel_cmd_t                owed_wheels[$];
  wheel_cmd_t                want;
  int                        beat_idx;

  function automatic logic [SPEED_W-1:0] clamp_speed(longint v);
    if (v < 0) return '0;
    if (v > PWM_TOP) return SPEED_W'(PWM_TOP);
    return SPEED_W'(v);
  endfunction

  function automatic wheel_cmd_t steer_wheels(logic [SAMPLE_BITS-1:0] l,
                                              logic [SAMPLE_BITS-1:0] r);
    mode_t      seen;
    mode_t      mode;
    longint     diff;
    longint     num;
    longint     turn;
    wheel_cmd_t cmd;
    if (l < BLACK_LEVEL && r < BLACK_LEVEL) seen = MODE_WHITE;
    else if (l > BLACK_LEVEL && r > BLACK_LEVEL) seen = MODE_PD;
    else if (r > BLACK_LEVEL && l < BLACK_LEVEL) seen = MODE_RIGHT;
    else seen = MODE_LEFT;
    mode = seen;
    if (seen == MODE_LEFT || seen == MODE_RIGHT) begin
      side_mem = seen;
      mode = MODE_PD;
    end else if (seen == MODE_WHITE) begin
      mode = side_mem;
    end
    turn = 0;
    case (mode)
      MODE_PD: begin
        diff = longint'(l) - longint'(r);
        num = longint'(p_gain) * diff + longint'(d_gain) * (diff - prev_diff);
        turn = num / TURN_DIVISOR;
        prev_diff = diff;
      end
      MODE_LEFT:  turn = SIDE_OFFSET;
      MODE_RIGHT: turn = -SIDE_OFFSET;
      default:    turn = 0;
    endcase
    cmd.left_speed  = clamp_speed(BASE_SPEED + longint'(trim) - turn);
    cmd.right_speed = clamp_speed(BASE_SPEED - longint'(trim) + turn);
    cmd.mode        = mode;
    return cmd;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] wheel beat %0d: %s", $realtime, beat_idx, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      trim       = '0;
      p_gain     = PGAIN_W'(1600);
      d_gain     = DGAIN_W'(5);
      side_mem   = MODE_WHITE;
      prev_diff  = 0;
      beat_idx   = 0;
      fail_count = 0;
      owed_wheels.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ALIGN: trim = cfg_data[ALIGN_W-1:0];
          CFG_PGAIN: p_gain = cfg_data[PGAIN_W-1:0];
          CFG_DGAIN: d_gain = cfg_data[DGAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        owed_wheels.push_back(steer_wheels(in_left_sample, in_right_sample));
      end
      if (out_valid && !out_stall) begin
        if (owed_wheels.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (mode %0d, %0d/%0d)",
                                    out_drive_mode, out_left_speed, out_right_speed));
        end else begin
          want = owed_wheels.pop_front();
          if (out_left_speed !== want.left_speed)
            report_mismatch($sformatf("left_speed got %0d expected %0d",
                                      out_left_speed, want.left_speed));
          if (out_right_speed !== want.right_speed)
            report_mismatch($sformatf("right_speed got %0d expected %0d",
                                      out_right_speed, want.right_speed));
          if (out_drive_mode !== want.mode)
            report_mismatch($sformatf("drive_mode got %0d expected %0d",
                                      out_drive_mode, want.mode));
        end
        beat_idx++;
      end
    end
    wheels_owed <= owed_wheels.size();
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives sample pairs into the line follower with bursty valid and a
// changing stall pattern on the result side. It first runs a directed set of
// threshold and extreme cases, then random pairs under several register
// settings written while the block is idle. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lfps_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 7;
  localparam int PHASE_BEATS = 58;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] in_left_sample = '0;
  logic [SAMPLE_BITS-1:0] in_right_sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SPEED_W-1:0]     out_left_speed;
  logic [SPEED_W-1:0]     out_right_speed;
  logic [1:0]             out_drive_mode;
  logic                   cfg_wr_en = 1'b0;
  logic [1:0]             cfg_index = CFG_ALIGN;
  logic [CFG_W-1:0]       cfg_data = '0;

  int fail_count;
  int wheels_owed;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_style = 0;
  int stall_span = 0;

  ir_line_follow_pd_steer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_speed  (out_left_speed),
    .out_right_speed (out_right_speed),
    .out_drive_mode  (out_drive_mode),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  line_follow_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_speed  (out_left_speed),
    .out_right_speed (out_right_speed),
    .out_drive_mode  (out_drive_mode),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .wheels_owed     (wheels_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_span  <= $urandom_range(10, 60);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  task automatic send_pair(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid        <= 1'b1;
    in_left_sample  <= l;
    in_right_sample <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (wheels_owed != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] align, input logic [CFG_W-1:0] pg,
                                input logic [CFG_W-1:0] dg);
    write_reg(CFG_ALIGN, align);
    write_reg(CFG_PGAIN, pg);
    write_reg(CFG_DGAIN, dg);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return SAMPLE_BITS'($urandom_range(0, 12'h9FF));
      1:       return SAMPLE_BITS'($urandom_range(12'hA01, 12'hFFF));
      2:       return SAMPLE_BITS'($urandom_range(12'h9F8, 12'hA08));
      3:       return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      4:       return BLACK_LEVEL;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair(12'h000, 12'h000);
    send_pair(12'hFFF, 12'hFFF);
    send_pair(12'hA00, 12'hA00);
    send_pair(12'h9FF, 12'h9FF);
    send_pair(12'h9FF, 12'hA01);
    send_pair(12'h000, 12'h000);
    send_pair(12'hA01, 12'h9FF);
    send_pair(12'hFFF, 12'h000);
    send_pair(12'h000, 12'hFFF);
    send_pair(12'hA01, 12'hA01);
    send_pair(12'hA00, 12'hA01);
    send_pair(12'hA01, 12'hA00);
    send_pair(12'h9FF, 12'hA00);
    send_pair(12'hA00, 12'h9FF);
    send_pair(12'hFFF, 12'hA01);
    send_pair(12'hA01, 12'hFFF);
    send_pair(12'h555, 12'hAAA);
    send_pair(12'h3FF, 12'h200);
    send_pair(12'hAAA, 12'h555);
    send_pair(12'h000, 12'h9FF);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1:       apply_settings(CFG_W'(-512), CFG_W'(4000), CFG_W'(100));
          2:       apply_settings(CFG_W'(512), CFG_W'(0), CFG_W'(0));
          3:       apply_settings(CFG_W'(12'h400), CFG_W'(4095), CFG_W'(127));
          4:       apply_settings(CFG_W'(1023), CFG_W'(1600), CFG_W'(5));
          default: apply_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        endcase
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (phase == 2 && n == PHASE_BEATS / 2) drain();
        if ($urandom_range(0, 4) == 0)
          send_pair(SAMPLE_BITS'($urandom_range(0, 12'h9FF)),
                    SAMPLE_BITS'($urandom_range(0, 12'h9FF)));
        else
          send_pair(pick_sample(), pick_sample());
      end
    end

    drain();
    if (fail_count == 0 && wheels_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
sv/lfps_pkg.sv
sv/lfps_front.sv
sv/lfps_div.sv
sv/lfps_out.sv
sv/ir_line_follow_pd_steer.sv
test/line_follow_checker.sv
test/testbench.sv
